// ===== design/iitf_pkg.sv =====
// ----------------------------------------------------------------------------
// iitf_pkg
// Shared types and constants for the inverted index term-frequency builder.
// ----------------------------------------------------------------------------
package iitf_pkg;

    // Default sizing of the index
    localparam int VOCAB_DEFAULT        = 1024;
    localparam int MAX_POSTINGS_DEFAULT = 64;

    // Field widths
    localparam int DOC_W    = 16;
    localparam int WORD_W   = 20;
    localparam int LEN_W    = 16;
    localparam int WEIGHT_W = 17;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int CNT_W    = 7;
    localparam int TOTAL_W  = 11;

    // Q1.16 constants
    localparam logic [WEIGHT_W-1:0] ONE_Q16    = 17'h10000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 17'h1FFFF;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = 11'h7FF;

    // Reciprocal divider: one quotient bit per step
    localparam int DIV_STEPS = WEIGHT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW  = 2'd0,
        ST_ACC  = 2'd1,
        ST_FULL = 2'd2,
        ST_OOR  = 2'd3
    } status_t;

    // Controller -> datapath
    typedef struct packed {
        logic clr_step;
        logic load;
        logic div_step;
        logic scan_step;
        logic capture;
        logic commit;
    } iitf_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic in_oor;
        logic div_last;
        logic hit;
        logic miss;
        logic out_free;
    } iitf_stat_t;

endpackage

// ===== design/iitf_ifs.sv =====
// ----------------------------------------------------------------------------
// iitf channel interfaces
// Word occurrence channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface iitf_occ_if import iitf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DOC_W-1:0]    document_number;
    logic [WORD_W-1:0]   word_number;
    logic [LEN_W-1:0]    document_length;

    modport source (output valid, output document_number, output word_number,
                    output document_length, input ready);
    modport sink   (input valid, input document_number, input word_number,
                    input document_length, output ready);
endinterface

interface iitf_res_if import iitf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [WEIGHT_W-1:0] posting_value;
    logic [CNT_W-1:0]    postings_in_word;
    logic [TOTAL_W-1:0]  distinct_words;

    modport source (output valid, output status, output slot_index,
                    output posting_value, output postings_in_word,
                    output distinct_words, input ready);
    modport sink   (input valid, input status, input slot_index,
                    input posting_value, input postings_in_word,
                    input distinct_words, output ready);
endinterface

// ===== design/iitf_ctrl.sv =====
// ----------------------------------------------------------------------------
// iitf_ctrl
// Sequencer: clear pass, reciprocal divide, posting scan, commit.
// ----------------------------------------------------------------------------
module iitf_ctrl import iitf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       occ_valid,
    output logic       occ_ready,
    input  iitf_stat_t stat,
    output iitf_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_DIV    = 5'b00100,
        S_SCAN   = 5'b01000,
        S_COMMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        occ_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                occ_ready = 1'b1;
                if (occ_valid)
                begin
                    cmd.load   = 1'b1;
                    // out-of-range words skip divide and scan
                    state_next = stat.in_oor ? S_COMMIT : S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.hit || stat.miss)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== design/iitf_datapath.sv =====
// ----------------------------------------------------------------------------
// iitf_datapath
// Count and posting memories, reciprocal divider, scan pipe, result register.
// ----------------------------------------------------------------------------
module iitf_datapath import iitf_pkg::*;
#(
    parameter int VOCAB        = VOCAB_DEFAULT,
    parameter int MAX_POSTINGS = MAX_POSTINGS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  iitf_cmd_t           cmd,
    output iitf_stat_t          stat,
    input  logic [DOC_W-1:0]    document_number,
    input  logic [WORD_W-1:0]   word_number,
    input  logic [LEN_W-1:0]    document_length,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot_index,
    output logic [WEIGHT_W-1:0] posting_value,
    output logic [CNT_W-1:0]    postings_in_word,
    output logic [TOTAL_W-1:0]  distinct_words
);

    localparam int VW    = (VOCAB > 1) ? $clog2(VOCAB) : 1;
    localparam int KW    = (MAX_POSTINGS > 1) ? $clog2(MAX_POSTINGS) : 1;
    localparam int CW    = $clog2(MAX_POSTINGS + 1);
    localparam int AW    = VW + KW;
    localparam int PDEPTH = 1 << AW;
    localparam int PW    = DOC_W + WEIGHT_W;

    // ---------------- item registers ----------------
    logic [DOC_W-1:0]  doc_reg;
    logic [VW-1:0]     x_reg;
    logic              oor_reg;
    logic [WORD_W-1:0] word_m1;
    logic [WORD_W:0]   vocab_lim;

    assign word_m1     = word_number - WORD_W'(1);
    assign vocab_lim   = (WORD_W+1)'(VOCAB);
    assign stat.in_oor = (word_number == '0) || ({1'b0, word_number} > vocab_lim);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            doc_reg <= document_number;
            x_reg   <= word_m1[VW-1:0];
            oor_reg <= stat.in_oor;
        end
    end

    // ---------------- reciprocal divider (restoring) ----------------
    logic [WEIGHT_W-1:0]  q_reg;
    logic [LEN_W-1:0]     rem_reg;
    logic [LEN_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [LEN_W:0]       trial;
    logic                 trial_ge;
    logic [LEN_W:0]       trial_sub;

    assign trial         = {rem_reg, q_reg[WEIGHT_W-1]};
    assign trial_ge      = trial >= {1'b0, dvs_reg};
    assign trial_sub     = trial - {1'b0, dvs_reg};
    assign stat.div_last = (dcnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_reg    <= ONE_Q16;
            rem_reg  <= '0;
            dcnt_reg <= '0;
            dvs_reg  <= (document_length == '0) ? LEN_W'(1) : document_length;
        end
        else if (cmd.div_step)
        begin
            q_reg    <= {q_reg[WEIGHT_W-2:0], trial_ge};
            rem_reg  <= trial_ge ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
            dcnt_reg <= dcnt_reg + DIV_CNT_W'(1);
        end
    end

    // ---------------- posting count memory ----------------
    logic [CW-1:0] cnt_mem [VOCAB];
    logic [CW-1:0] cnt_rd_reg;
    logic [VW-1:0] clr_idx_reg;
    logic          cnt_we;
    logic [CW-1:0] n_inc;

    assign n_inc         = cnt_rd_reg + CW'(1);
    assign stat.clr_last = (clr_idx_reg == VW'(VOCAB - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_idx_reg <= clr_idx_reg + VW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            cnt_mem[clr_idx_reg] <= '0;
        end
        else if (cnt_we)
        begin
            cnt_mem[x_reg] <= n_inc;
        end
        cnt_rd_reg <= cnt_mem[x_reg];
    end

    // ---------------- posting memory {document, weight} ----------------
    logic [PW-1:0]       post_mem [PDEPTH];
    logic [PW-1:0]       rd_reg;
    logic                post_we;
    logic [AW-1:0]       post_waddr;
    logic [PW-1:0]       post_wdata;
    logic [CW-1:0]       k_reg;
    logic [CW-1:0]       chk_k_reg;
    logic                chk_valid_reg;
    logic [DOC_W-1:0]    rd_doc;
    logic [WEIGHT_W-1:0] rd_weight;

    assign rd_doc    = rd_reg[PW-1:WEIGHT_W];
    assign rd_weight = rd_reg[WEIGHT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (post_we)
        begin
            post_mem[post_waddr] <= post_wdata;
        end
        rd_reg <= post_mem[{x_reg, k_reg[KW-1:0]}];
    end

    // scan: read slot k, compare it in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            chk_valid_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            chk_valid_reg <= (k_reg < cnt_rd_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            k_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            chk_k_reg <= k_reg;
            if (k_reg < cnt_rd_reg)
            begin
                k_reg <= k_reg + CW'(1);
            end
        end
    end

    assign stat.hit  = chk_valid_reg && (rd_doc == doc_reg);
    assign stat.miss = !chk_valid_reg && (k_reg == cnt_rd_reg);

    logic                hit_reg;
    logic [CW-1:0]       slot_reg;
    logic [WEIGHT_W-1:0] w_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            hit_reg  <= stat.hit;
            slot_reg <= chk_k_reg;
            w_reg    <= rd_weight;
        end
    end

    // ---------------- commit decode ----------------
    logic [WEIGHT_W:0]   sum;
    logic [WEIGHT_W-1:0] acc_val;
    logic                full;
    logic [CW+SLOT_W-1:0] slot_hit_ext;
    logic [CW+SLOT_W-1:0] slot_new_ext;
    logic [CW+CNT_W-1:0]  cnt_ext;
    logic [CW+CNT_W-1:0]  cnt_inc_ext;

    assign sum          = {1'b0, w_reg} + {1'b0, q_reg};
    assign acc_val      = sum[WEIGHT_W] ? WEIGHT_MAX : sum[WEIGHT_W-1:0];
    assign full         = (cnt_rd_reg >= CW'(MAX_POSTINGS));
    assign slot_hit_ext = {{SLOT_W{1'b0}}, slot_reg};
    assign slot_new_ext = {{SLOT_W{1'b0}}, cnt_rd_reg};
    assign cnt_ext      = {{CNT_W{1'b0}}, cnt_rd_reg};
    assign cnt_inc_ext  = {{CNT_W{1'b0}}, n_inc};

    logic                res_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   slot_out_reg;
    logic [WEIGHT_W-1:0] value_out_reg;
    logic [CNT_W-1:0]    cnt_out_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  total_next;
    status_t             status_next;
    logic [SLOT_W-1:0]   slot_out_next;
    logic [WEIGHT_W-1:0] value_out_next;
    logic [CNT_W-1:0]    cnt_out_next;

    always_comb
    begin
        post_we        = 1'b0;
        post_waddr     = {x_reg, cnt_rd_reg[KW-1:0]};
        post_wdata     = {doc_reg, q_reg};
        cnt_we         = 1'b0;
        total_next     = total_reg;
        status_next    = ST_OOR;
        slot_out_next  = '0;
        value_out_next = '0;
        cnt_out_next   = '0;
        if (oor_reg)
        begin
            status_next = ST_OOR;
        end
        else if (hit_reg)
        begin
            post_we        = cmd.commit;
            post_waddr     = {x_reg, slot_reg[KW-1:0]};
            post_wdata     = {doc_reg, acc_val};
            status_next    = ST_ACC;
            slot_out_next  = slot_hit_ext[SLOT_W-1:0];
            value_out_next = acc_val;
            cnt_out_next   = cnt_ext[CNT_W-1:0];
        end
        else if (full)
        begin
            status_next  = ST_FULL;
            cnt_out_next = cnt_ext[CNT_W-1:0];
        end
        else
        begin
            post_we        = cmd.commit;
            cnt_we         = cmd.commit;
            status_next    = ST_NEW;
            slot_out_next  = slot_new_ext[SLOT_W-1:0];
            value_out_next = q_reg;
            cnt_out_next   = cnt_inc_ext[CNT_W-1:0];
            if ((cnt_rd_reg == '0) && (total_reg != TOTAL_MAX))
            begin
                total_next = total_reg + TOTAL_W'(1);
            end
        end
    end

    // ---------------- result register ----------------
    assign stat.out_free = !res_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                res_valid_reg <= 1'b1;
                total_reg     <= total_next;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg    <= status_next;
            slot_out_reg  <= slot_out_next;
            value_out_reg <= value_out_next;
            cnt_out_reg   <= cnt_out_next;
        end
    end

    assign res_valid        = res_valid_reg;
    assign status           = status_reg;
    assign slot_index       = slot_out_reg;
    assign posting_value    = value_out_reg;
    assign postings_in_word = cnt_out_reg;
    assign distinct_words   = total_reg;

endmodule

// ===== design/inverted_index_tf_builder.sv =====
// ----------------------------------------------------------------------------
// inverted_index_tf_builder
// Normalized term-frequency inverted index, one word occurrence per
// transaction, one result transaction back.
// ----------------------------------------------------------------------------
//  channel      dir  handshake      payload
//  occurrence   in   valid/ready    document_number, word_number, document_length
//  result       out  valid/ready    status, slot_index, posting_value,
//                                   postings_in_word, distinct_words
//
//  Steps: accept, divide, scan, commit; the divide yields one bit a cycle and
//  the scan reads the postings through the single posting memory read port.
//  Out-of-range words skip divide and scan and go straight to commit.
//  Reset: a clearing pass zeroes the count memory, one word a cycle; no
//  occurrence is taken until it ends.
//  Stalls: a new occurrence is taken while the result waits in its output
//  register; the commit of that occurrence holds until the result drains.
// ----------------------------------------------------------------------------
module inverted_index_tf_builder import iitf_pkg::*;
#(
    parameter int VOCAB        = VOCAB_DEFAULT,
    parameter int MAX_POSTINGS = MAX_POSTINGS_DEFAULT
)
(
    input logic         clk,
    input logic         rst_n,
    iitf_occ_if.sink    occurrence,
    iitf_res_if.source  result
);

    iitf_cmd_t  cmd;
    iitf_stat_t stat;

    // sequencer: clear, divide, scan, commit
    iitf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .occ_valid (occurrence.valid),
        .occ_ready (occurrence.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // memories, divider, scan compare and the result register
    iitf_datapath #(
        .VOCAB        (VOCAB),
        .MAX_POSTINGS (MAX_POSTINGS)
    ) u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .document_number  (occurrence.document_number),
        .word_number      (occurrence.word_number),
        .document_length  (occurrence.document_length),
        .res_valid        (result.valid),
        .res_ready        (result.ready),
        .status           (result.status),
        .slot_index       (result.slot_index),
        .posting_value    (result.posting_value),
        .postings_in_word (result.postings_in_word),
        .distinct_words   (result.distinct_words)
    );

endmodule

// ===== design/iitf_checker.sv =====
// ----------------------------------------------------------------------------
// iitf_checker
// Port-level checks on the term-frequency builder, bound to the top level.
// ----------------------------------------------------------------------------
module iitf_checker import iitf_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                occ_valid,
    input logic                occ_ready,
    input logic                res_valid,
    input logic                res_ready,
    input logic [STATUS_W-1:0] status,
    input logic [SLOT_W-1:0]   slot_index,
    input logic [WEIGHT_W-1:0] posting_value,
    input logic [CNT_W-1:0]    postings_in_word
);

    // one occurrence in flight: ready drops right after a transaction
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        occ_valid && occ_ready |=> !occ_ready)
        else $error("occurrence accepted while another is in flight");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn before transaction");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_OOR) |->
            (slot_index == '0) && (posting_value == '0) && (postings_in_word == '0))
        else $error("out-of-range result carries nonzero fields");

    a_new_weight: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_NEW) |->
            (posting_value != '0) && (posting_value <= ONE_Q16))
        else $error("new posting weight outside reciprocal range");

endmodule

bind inverted_index_tf_builder iitf_checker u_iitf_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .occ_valid        (occurrence.valid),
    .occ_ready        (occurrence.ready),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .status           (result.status),
    .slot_index       (result.slot_index),
    .posting_value    (result.posting_value),
    .postings_in_word (result.postings_in_word)
);
